@@ design/tcaq_pkg.sv @@
// Shared types and constants for the Type-C attach qualifier.
// Used by tcaq_decide and typec_attach_qualifier; depends on nothing.

package tcaq_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_DEBUG_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_UNATTACHED_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0] DEVICE_LIMIT_RST     = 2'd2;
    localparam logic [1:0] DEBUG_LIMIT_RST      = 2'd1;
    localparam logic [1:0] UNATTACHED_LIMIT_RST = 2'd3;

    // Interrupt byte codes.
    localparam logic [7:0] IRQ_NONE     = 8'h00;
    localparam logic [7:0] IRQ_ATTACHED = 8'h01;
    localparam logic [7:0] IRQ_DETACHED = 8'h02;

    // CC status codes of the case table.
    localparam logic [7:0] CC_IDLE        = 8'h00;
    localparam logic [7:0] CC_DEVICE_A    = 8'h05;
    localparam logic [7:0] CC_DEVICE_B    = 8'h06;
    localparam logic [7:0] CC_DEBUG       = 8'h13;
    localparam logic [7:0] CC_NOTHING     = 8'ha8;
    localparam logic [7:0] CC_AUDIO       = 8'h0f;
    localparam logic [7:0] CC_DEBUG_VBUS  = 8'h93;
    localparam logic [7:0] CC_AUDIO_VBUS  = 8'h8f;
    localparam logic [7:0] CC_UNATTACHED  = 8'h97;
    localparam logic [7:0] CC_VBUS_MASK   = 8'h7f;
    localparam logic [7:0] CC_HOST_0      = 8'ha9;
    localparam logic [7:0] CC_HOST_1      = 8'haa;
    localparam logic [7:0] CC_HOST_2      = 8'hc9;
    localparam logic [7:0] CC_HOST_3      = 8'hca;
    localparam logic [7:0] CC_HOST_4      = 8'he9;
    localparam logic [7:0] CC_HOST_5      = 8'hea;

    // Output codes.
    localparam logic [1:0] POL_UNKNOWN = 2'd0;
    localparam logic [1:0] POL_CC1     = 2'd1;
    localparam logic [1:0] POL_CC2     = 2'd2;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ATTACHED = 2'd1;
    localparam logic [1:0] EV_DETACHED = 2'd2;

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_NOTHING = 3'd1;
    localparam logic [2:0] KIND_DEVICE  = 3'd2;
    localparam logic [2:0] KIND_HOST    = 3'd3;
    localparam logic [2:0] KIND_AUDIO   = 3'd4;
    localparam logic [2:0] KIND_DEBUG   = 3'd5;

    localparam logic [2:0] PORT_NOTHING = 3'd0;
    localparam logic [2:0] PORT_DEVICE  = 3'd1;
    localparam logic [2:0] PORT_HOST    = 3'd2;
    localparam logic [2:0] PORT_AUDIO   = 3'd3;
    localparam logic [2:0] PORT_DEBUG   = 3'd4;

    typedef struct packed {
        logic [1:0] retry_count;
        logic       audio_seen;
        logic       debug_seen;
    } state_t;

    typedef struct packed {
        logic [1:0] device_limit;
        logic [1:0] debug_limit;
        logic [1:0] unattached_limit;
    } limits_t;

    typedef struct packed {
        logic       vbus_present;
        logic [1:0] cc_polarity;
        logic [1:0] event_kind;
        logic [2:0] attached_kind;
        logic [1:0] charge_current;
        logic       not_settled;
        logic       retoggle_port;
    } result_t;

endpackage

@@ design/tcaq_decide.sv @@
// Case table and status decode for one poll of the CC logic chip.
// Purely combinational; uses the types and codes of tcaq_pkg.

module tcaq_decide
    import tcaq_pkg::*;
(
    input  logic [7:0] int_status,
    input  logic [7:0] cc_status,
    input  state_t     state,
    input  limits_t    limits,
    output result_t    result,
    output state_t     state_next
);

    function automatic result_t decode(input logic [7:0] irq, input logic [7:0] cc);
        result_t r;
        r = '0;
        r.vbus_present = cc[7];
        r.cc_polarity  = (cc[1:0] == POL_CC1 || cc[1:0] == POL_CC2) ? cc[1:0] : POL_UNKNOWN;
        if (irq[0] && !irq[1])
            r.event_kind = EV_ATTACHED;
        else if (irq[1] && !irq[0])
            r.event_kind = EV_DETACHED;
        else
            r.event_kind = EV_NONE;
        case (cc[4:2])
            PORT_NOTHING: r.attached_kind = KIND_NOTHING;
            PORT_DEVICE:  r.attached_kind = KIND_DEVICE;
            PORT_HOST:    r.attached_kind = KIND_HOST;
            PORT_AUDIO:   r.attached_kind = KIND_AUDIO;
            PORT_DEBUG:   r.attached_kind = KIND_DEBUG;
            default:      r.attached_kind = KIND_UNKNOWN;
        endcase
        r.charge_current = cc[6:5];
        return r;
    endfunction

    logic is_host;
    logic flag;
    logic irq_att;
    logic irq_none;

    assign is_host = (cc_status == CC_HOST_0) || (cc_status == CC_HOST_1) ||
                     (cc_status == CC_HOST_2) || (cc_status == CC_HOST_3) ||
                     (cc_status == CC_HOST_4) || (cc_status == CC_HOST_5);
    assign flag     = (cc_status == CC_DEBUG_VBUS) ? state.debug_seen : state.audio_seen;
    assign irq_att  = (int_status == IRQ_ATTACHED);
    assign irq_none = (int_status == IRQ_NONE);

    always_comb
    begin
        // An undecoded poll reports a detach; only the flag bits may be set.
        result = '0;
        result.event_kind = EV_DETACHED;
        state_next = state;

        if (irq_att || irq_none)
        begin
            if (cc_status == CC_IDLE)
            begin
                state_next = '0;
            end
            else if (cc_status == CC_DEBUG_VBUS || cc_status == CC_AUDIO_VBUS)
            begin
                result = decode(int_status, flag ? (cc_status & CC_VBUS_MASK) : cc_status);
            end
            else if (is_host)
            begin
                result = decode(int_status, cc_status);
            end
            else if (irq_att && (cc_status == CC_DEVICE_A || cc_status == CC_DEVICE_B))
            begin
                if (state.retry_count >= limits.device_limit)
                begin
                    state_next.retry_count = '0;
                    result = decode(int_status, cc_status);
                end
                else
                begin
                    state_next.retry_count = state.retry_count + 2'd1;
                    result.retoggle_port = 1'b1;
                    result.not_settled   = 1'b1;
                end
            end
            else if (irq_att && cc_status == CC_DEBUG)
            begin
                if (state.retry_count >= limits.debug_limit)
                begin
                    state_next.retry_count = '0;
                    state_next.debug_seen  = 1'b1;
                    result = decode(int_status, cc_status);
                end
                else
                begin
                    state_next.retry_count = state.retry_count + 2'd1;
                    state_next.debug_seen  = 1'b0;
                    result.retoggle_port   = 1'b1;
                end
            end
            else if (irq_att && cc_status == CC_NOTHING)
            begin
                // Accepted, but there is nothing to decode.
            end
            else if (irq_att && cc_status == CC_AUDIO)
            begin
                state_next.audio_seen = 1'b1;
                result = decode(int_status, cc_status);
            end
            else if (irq_none && cc_status == CC_UNATTACHED)
            begin
                // With an accessory present the unattached code is ignored.
                if (!(state.debug_seen || state.audio_seen))
                begin
                    if (state.retry_count >= limits.unattached_limit)
                    begin
                        state_next.retry_count = '0;
                    end
                    else
                    begin
                        state_next.retry_count = state.retry_count + 2'd1;
                        result.retoggle_port   = 1'b1;
                    end
                end
            end
            else
            begin
                result.not_settled = 1'b1;
            end
        end
        else if (int_status == IRQ_DETACHED)
        begin
            state_next = '0;
            result = decode(int_status, cc_status);
        end
        else
        begin
            state_next = '0;
        end
    end

endmodule

@@ design/typec_attach_qualifier.sv @@
// Top level of the Type-C attach qualifier: state, configuration and output buffer.
// Uses tcaq_pkg and tcaq_decide.
//
// Usage: each request on the input channel (in_valid, in_stall) carries one poll of
// the CC logic chip, int_status and cc_status. Every poll gives exactly one result on
// the output channel (out_valid, out_stall), in order.
// A poll accepted while the output register is free has its result registered there;
// otherwise the result goes to the skid register. One poll per cycle is taken while in_stall
// is low: the case table and retry counter update are combinational from the input ports.
// A two-entry output buffer (output register plus skid register) lets a poll be taken
// while a result waits; in_stall rises only when both entries are full.
// Configuration: the retry limits are written through cfg_valid/cfg_ready with a
// register index and two data bits; cfg_ready is always high. Writes are meant for
// idle times only. Indexes past the last register are ignored.
// Reset: rst_n clears the retry counter, the accessory flags and both buffer
// entries, and loads the limits with 2 (device), 1 (debug) and 3 (unattached).
// While out_stall holds, the pending result stays on the outputs unchanged.

module typec_attach_qualifier
    import tcaq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] int_status,
    input  logic [7:0] cc_status,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       vbus_present,
    output logic [1:0] cc_polarity,
    output logic [1:0] event_kind,
    output logic [2:0] attached_kind,
    output logic [1:0] charge_current,
    output logic       not_settled,
    output logic       retoggle_port,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    state_t  state_reg, state_next, state_dec;
    limits_t limits_reg, limits_next;
    result_t result;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    in_acc;
    logic    out_take;

    tcaq_decide u_decide (
        .int_status (int_status),
        .cc_status  (cc_status),
        .state      (state_reg),
        .limits     (limits_reg),
        .result     (result),
        .state_next (state_dec)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_LIMIT:     limits_next.device_limit     = cfg_data;
                CFG_DEBUG_LIMIT:      limits_next.debug_limit      = cfg_data;
                CFG_UNATTACHED_LIMIT: limits_next.unattached_limit = cfg_data;
                default:              limits_next = limits_reg;
            endcase
        end
    end

    assign state_next = in_acc ? state_dec : state_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            // The skid entry is older than anything arriving now; while it is full
            // no request is accepted.
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_acc)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= '0;
            limits_reg.device_limit     <= DEVICE_LIMIT_RST;
            limits_reg.debug_limit      <= DEBUG_LIMIT_RST;
            limits_reg.unattached_limit <= UNATTACHED_LIMIT_RST;
            out_valid_reg               <= 1'b0;
            skid_valid_reg              <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limits_reg     <= limits_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign vbus_present   = out_reg.vbus_present;
    assign cc_polarity    = out_reg.cc_polarity;
    assign event_kind     = out_reg.event_kind;
    assign attached_kind  = out_reg.attached_kind;
    assign charge_current = out_reg.charge_current;
    assign not_settled    = out_reg.not_settled;
    assign retoggle_port  = out_reg.retoggle_port;

endmodule

@@ design/tcaq_checker.sv @@
// Port-level checks for typec_attach_qualifier, bound to the top level.
// Uses the output codes of tcaq_pkg.

module tcaq_checker
    import tcaq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       vbus_present,
    input logic [1:0] cc_polarity,
    input logic [1:0] event_kind,
    input logic [2:0] attached_kind,
    input logic [1:0] charge_current,
    input logic       not_settled,
    input logic       retoggle_port
);

    // A stalled result must not vanish.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A request taken with the output empty shows its result in the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> out_valid)
        else $error("accepted request produced no result");

    // A re-toggle request is never combined with a decoded status.
    a_retoggle_undecoded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && retoggle_port |->
            event_kind == EV_DETACHED && attached_kind == KIND_UNKNOWN &&
            !vbus_present && charge_current == 2'd0)
        else $error("re-toggle with decoded fields");

    // An unsettled poll carries the not-decoded fields.
    a_unsettled_undecoded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_settled |->
            event_kind == EV_DETACHED && cc_polarity == POL_UNKNOWN && !vbus_present)
        else $error("unsettled result with decoded fields");

    // Polarity, event and kind stay within their defined codes.
    a_codes_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cc_polarity != 2'd3 && event_kind != 2'd3 && attached_kind <= KIND_DEBUG)
        else $error("output code out of range");

endmodule

bind typec_attach_qualifier tcaq_checker u_tcaq_checker (.*);

@@ sim/tb_top.sv @@
// Testbench for typec_attach_qualifier: directed polls, then random polls under several
// retry limit settings, each result checked against a listed value or a predictor here.
// Depends on tcaq_pkg and the typec_attach_qualifier RTL.

module tb_top
    import tcaq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 8;
    localparam int PHASE_POLLS  = 55;

    // Register index with no register behind it.
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] int_status;
    logic [7:0] cc_status;
    logic       out_valid;
    logic       out_stall;
    logic       vbus_present;
    logic [1:0] cc_polarity;
    logic [1:0] event_kind;
    logic [2:0] attached_kind;
    logic [1:0] charge_current;
    logic       not_settled;
    logic       retoggle_port;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;

    typedef struct {
        logic [7:0] irq;
        logic [7:0] cc;
        bit         typed;
        result_t    want;
    } poll_row_t;

    // Predictor copy of the block's state and limits.
    state_t    qual_state = '0;
    limits_t   qual_limits = '{DEVICE_LIMIT_RST, DEBUG_LIMIT_RST, UNATTACHED_LIMIT_RST};
    result_t   pending_results[$];
    poll_row_t poll_rows[$];

    int  err_count    = 0;
    int  polls_sent   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    bit  tx_quiet     = 0;
    bit  rx_quiet     = 0;
    bit  rx_hold      = 0;

    typec_attach_qualifier i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .int_status     (int_status),
        .cc_status      (cc_status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vbus_present   (vbus_present),
        .cc_polarity    (cc_polarity),
        .event_kind     (event_kind),
        .attached_kind  (attached_kind),
        .charge_current (charge_current),
        .not_settled    (not_settled),
        .retoggle_port  (retoggle_port),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic result_t outcome(logic vbus, logic [1:0] pol, logic [1:0] ev,
                                        logic [2:0] kind, logic [1:0] cur, logic ns,
                                        logic rt);
        result_t r;
        r.vbus_present   = vbus;
        r.cc_polarity    = pol;
        r.event_kind     = ev;
        r.attached_kind  = kind;
        r.charge_current = cur;
        r.not_settled    = ns;
        r.retoggle_port  = rt;
        return r;
    endfunction

    function automatic result_t decode_status(logic [7:0] irq, logic [7:0] cc);
        result_t r;
        r = '0;
        r.vbus_present = cc[7];
        r.cc_polarity  = (cc[1:0] == POL_CC1 || cc[1:0] == POL_CC2) ? cc[1:0] : POL_UNKNOWN;
        // Both the attached and the detached bit together mean no event.
        if (irq[0] && !irq[1])
            r.event_kind = EV_ATTACHED;
        else if (irq[1] && !irq[0])
            r.event_kind = EV_DETACHED;
        else
            r.event_kind = EV_NONE;
        case (cc[4:2])
            PORT_NOTHING: r.attached_kind = KIND_NOTHING;
            PORT_DEVICE:  r.attached_kind = KIND_DEVICE;
            PORT_HOST:    r.attached_kind = KIND_HOST;
            PORT_AUDIO:   r.attached_kind = KIND_AUDIO;
            PORT_DEBUG:   r.attached_kind = KIND_DEBUG;
            default:      r.attached_kind = KIND_UNKNOWN;
        endcase
        r.charge_current = cc[6:5];
        return r;
    endfunction

    function automatic bit is_host_status(logic [7:0] cc);
        case (cc)
            CC_HOST_0, CC_HOST_1, CC_HOST_2, CC_HOST_3, CC_HOST_4, CC_HOST_5: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Advances the predictor state by one poll and returns the qualified result.
    task automatic qualify_poll(input logic [7:0] irq, input logic [7:0] cc,
                                output result_t r);
        logic ns;
        logic rt;
        ns = 1'b0;
        rt = 1'b0;
        r  = outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd0, 1'b0, 1'b0);
        if (irq == IRQ_ATTACHED || irq == IRQ_NONE)
        begin
            if (cc == CC_IDLE)
                qual_state = '0;
            else if (cc == CC_DEBUG_VBUS)
                r = decode_status(irq, qual_state.debug_seen ? (cc & CC_VBUS_MASK) : cc);
            else if (cc == CC_AUDIO_VBUS)
                r = decode_status(irq, qual_state.audio_seen ? (cc & CC_VBUS_MASK) : cc);
            else if (is_host_status(cc))
                r = decode_status(irq, cc);
            else if (irq == IRQ_ATTACHED && (cc == CC_DEVICE_A || cc == CC_DEVICE_B))
            begin
                if (qual_state.retry_count >= qual_limits.device_limit)
                begin
                    qual_state.retry_count = 2'd0;
                    r = decode_status(irq, cc);
                end
                else
                begin
                    qual_state.retry_count = qual_state.retry_count + 2'd1;
                    rt = 1'b1;
                    ns = 1'b1;
                end
            end
            else if (irq == IRQ_ATTACHED && cc == CC_DEBUG)
            begin
                if (qual_state.retry_count >= qual_limits.debug_limit)
                begin
                    qual_state.retry_count = 2'd0;
                    qual_state.debug_seen  = 1'b1;
                    r = decode_status(irq, cc);
                end
                else
                begin
                    qual_state.retry_count = qual_state.retry_count + 2'd1;
                    qual_state.debug_seen  = 1'b0;
                    rt = 1'b1;
                end
            end
            else if (irq == IRQ_ATTACHED && cc == CC_NOTHING)
            begin
                // Accepted, but nothing to decode.
            end
            else if (irq == IRQ_ATTACHED && cc == CC_AUDIO)
            begin
                qual_state.audio_seen = 1'b1;
                r = decode_status(irq, cc);
            end
            else if (irq == IRQ_NONE && cc == CC_UNATTACHED)
            begin
                // With an accessory present the unattached code is simply ignored.
                if (!(qual_state.debug_seen || qual_state.audio_seen))
                begin
                    if (qual_state.retry_count >= qual_limits.unattached_limit)
                        qual_state.retry_count = 2'd0;
                    else
                    begin
                        qual_state.retry_count = qual_state.retry_count + 2'd1;
                        rt = 1'b1;
                    end
                end
            end
            else
                ns = 1'b1;
        end
        else if (irq == IRQ_DETACHED)
        begin
            qual_state = '0;
            r = decode_status(irq, cc);
        end
        else
            qual_state = '0;
        r.not_settled   = ns;
        r.retoggle_port = rt;
    endtask

    task automatic send_poll(input logic [7:0] irq, input logic [7:0] cc, input bit typed,
                             input result_t want);
        result_t predicted;
        in_valid   <= 1'b1;
        int_status <= irq;
        cc_status  <= cc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        qualify_poll(irq, cc, predicted);
        pending_results.push_back(typed ? want : predicted);
        polls_sent++;
    endtask

    task automatic sender_gap();
        if (!tx_quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEVICE_LIMIT:     qual_limits.device_limit     = data;
            CFG_DEBUG_LIMIT:      qual_limits.debug_limit      = data;
            CFG_UNATTACHED_LIMIT: qual_limits.unattached_limit = data;
            default: ;
        endcase
    endtask

    // Picks a cc code that the case table knows under the attached interrupt.
    function automatic logic [7:0] attach_code(int k);
        case (k)
            0:  return CC_DEVICE_A;
            1:  return CC_DEVICE_B;
            2:  return CC_DEBUG;
            3:  return CC_NOTHING;
            4:  return CC_AUDIO;
            5:  return CC_DEBUG_VBUS;
            6:  return CC_AUDIO_VBUS;
            7:  return CC_HOST_0;
            8:  return CC_HOST_1;
            9:  return CC_HOST_2;
            10: return CC_HOST_3;
            11: return CC_HOST_4;
            12: return CC_HOST_5;
            default: return CC_IDLE;
        endcase
    endfunction

    task automatic pick_poll(output logic [7:0] irq, output logic [7:0] cc);
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
        begin
            irq = IRQ_ATTACHED;
            cc  = attach_code($urandom_range(0, 13));
        end
        else if (k < 6)
        begin
            irq = IRQ_NONE;
            case ($urandom_range(0, 4))
                0, 1:    cc = CC_UNATTACHED;
                2:       cc = CC_DEBUG_VBUS;
                3:       cc = CC_AUDIO_VBUS;
                default: cc = attach_code($urandom_range(7, 13));
            endcase
        end
        else if (k == 6)
        begin
            irq = $urandom_range(0, 1) ? IRQ_ATTACHED : IRQ_NONE;
            cc  = 8'($urandom_range(0, 255));
        end
        else if (k == 7)
        begin
            irq = IRQ_DETACHED;
            cc  = 8'($urandom_range(0, 255));
        end
        else
        begin
            irq = 8'($urandom_range(0, 255));
            cc  = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic add_row(input logic [7:0] irq, input logic [7:0] cc, input bit typed,
                           input result_t want);
        poll_row_t row;
        row.irq   = irq;
        row.cc    = cc;
        row.typed = typed;
        row.want  = want;
        poll_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endtask

    // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                rx_hold = 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                err_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("vbus_present", exp_res.vbus_present, vbus_present);
                check_field("cc_polarity", exp_res.cc_polarity, cc_polarity);
                check_field("event_kind", exp_res.event_kind, event_kind);
                check_field("attached_kind", exp_res.attached_kind, attached_kind);
                check_field("charge_current", exp_res.charge_current, charge_current);
                check_field("not_settled", exp_res.not_settled, not_settled);
                check_field("retoggle_port", exp_res.retoggle_port, retoggle_port);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[typec_attach_qualifier] ERROR");
            $finish;
        end
    end

    initial
    begin
        result_t    idle_res;
        result_t    retry_res;
        result_t    unknown_res;
        logic [7:0] irq;
        logic [7:0] cc;
        logic [1:0] lim_dev;
        logic [1:0] lim_dbg;
        logic [1:0] lim_unatt;
        int         reps;
        int         phase_start;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        int_status <= 8'h00;
        cc_status  <= 8'h00;
        cfg_valid  <= 1'b0;
        cfg_index  <= 2'd0;
        cfg_data   <= 2'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_res    = outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd0, 1'b0, 1'b0);
        retry_res   = outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd0, 1'b1, 1'b1);
        unknown_res = outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd0, 1'b1, 1'b0);

        // Directed part, at the reset limits (device 2, debug 1, unattached 3).
        add_row(IRQ_ATTACHED, CC_DEVICE_A, 1'b1, retry_res);
        add_row(IRQ_ATTACHED, CC_DEVICE_B, 1'b1, retry_res);
        add_row(IRQ_ATTACHED, CC_DEVICE_A, 1'b1,
                outcome(1'b0, POL_CC1, EV_ATTACHED, KIND_DEVICE, 2'd0, 1'b0, 1'b0));
        add_row(IRQ_ATTACHED, CC_DEBUG, 1'b1,
                outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd0, 1'b0, 1'b1));
        add_row(IRQ_ATTACHED, CC_DEBUG, 1'b0, '0);
        add_row(IRQ_NONE, CC_DEBUG_VBUS, 1'b0, '0);
        add_row(IRQ_NONE, CC_UNATTACHED, 1'b0, '0);
        add_row(IRQ_DETACHED, 8'hff, 1'b1,
                outcome(1'b1, POL_UNKNOWN, EV_DETACHED, KIND_UNKNOWN, 2'd3, 1'b0, 1'b0));
        add_row(IRQ_NONE, CC_DEBUG_VBUS, 1'b0, '0);
        add_row(IRQ_ATTACHED, CC_AUDIO, 1'b0, '0);
        add_row(IRQ_ATTACHED, CC_AUDIO_VBUS, 1'b0, '0);
        add_row(IRQ_NONE, CC_UNATTACHED, 1'b0, '0);
        add_row(IRQ_ATTACHED, CC_NOTHING, 1'b1, idle_res);
        add_row(8'hff, 8'h00, 1'b1, idle_res);
        add_row(IRQ_NONE, CC_AUDIO_VBUS, 1'b0, '0);
        repeat (4) add_row(IRQ_NONE, CC_UNATTACHED, 1'b0, '0);
        add_row(IRQ_ATTACHED, CC_HOST_0, 1'b0, '0);
        add_row(IRQ_NONE, CC_HOST_3, 1'b0, '0);
        add_row(IRQ_ATTACHED, CC_HOST_5, 1'b0, '0);
        add_row(IRQ_NONE, CC_DEVICE_A, 1'b1, unknown_res);
        add_row(IRQ_ATTACHED, 8'hff, 1'b1, unknown_res);
        add_row(IRQ_NONE, CC_IDLE, 1'b1, idle_res);
        add_row(8'h03, 8'h55, 1'b1, idle_res);
        add_row(IRQ_DETACHED, 8'h00, 1'b1,
                outcome(1'b0, POL_UNKNOWN, EV_DETACHED, KIND_NOTHING, 2'd0, 1'b0, 1'b0));

        foreach (poll_rows[i])
        begin
            send_poll(poll_rows[i].irq, poll_rows[i].cc, poll_rows[i].typed, poll_rows[i].want);
            sender_gap();
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // The sender waits for every outstanding result before touching the limits.
            drain_results();
            repeat (3) @(posedge clk);
            case (phase)
                0:
                begin
                    lim_dev = 2'd3; lim_dbg = 2'd3; lim_unatt = 2'd3;
                end
                1:
                begin
                    lim_dev = 2'd0; lim_dbg = 2'd0; lim_unatt = 2'd0;
                end
                6:
                begin
                    lim_dev = DEVICE_LIMIT_RST; lim_dbg = DEBUG_LIMIT_RST;
                    lim_unatt = UNATTACHED_LIMIT_RST;
                end
                default:
                begin
                    lim_dev   = 2'($urandom_range(0, 3));
                    lim_dbg   = 2'($urandom_range(0, 3));
                    lim_unatt = 2'($urandom_range(0, 3));
                end
            endcase
            write_limit(CFG_DEVICE_LIMIT, lim_dev);
            write_limit(CFG_DEBUG_LIMIT, lim_dbg);
            write_limit(CFG_UNATTACHED_LIMIT, lim_unatt);
            if (phase == 0)
                write_limit(CFG_SPARE_INDEX, 2'($urandom_range(0, 3)));  // must be ignored
            cfg_valid <= 1'b0;

            if (phase == PHASES - 1)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end

            // Back-to-back requests into a long receiver hold-off fill the output buffer.
            if (phase == 2)
            begin
                rx_hold = 1'b1;
                repeat (14)
                begin
                    pick_poll(irq, cc);
                    send_poll(irq, cc, 1'b0, '0);
                end
            end

            phase_start = polls_sent;
            while (polls_sent - phase_start < PHASE_POLLS)
            begin
                pick_poll(irq, cc);
                // Repeated polls let the retry counters reach their limits.
                reps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
                repeat (reps)
                begin
                    send_poll(irq, cc, 1'b0, '0);
                    sender_gap();
                end
            end
        end

        drain_results();
        repeat (5) @(posedge clk);
        $display("Sent %0d polls and checked %0d results over %0d limit settings.",
                 polls_sent, results_seen, PHASES + 1);
        $display("Stimulus included retry runs, accessory masking, detach and unknown codes.");
        if (err_count == 0)
            $display("[typec_attach_qualifier] OK");
        else
            $display("[typec_attach_qualifier] ERROR");
        $finish;
    end

endmodule
